/* hdl/mtdd_pkg.sv */
package mtdd_pkg;

    localparam int TICK_W     = 32;
    localparam int END_W      = TICK_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam int W_DEAD    = 0;
    localparam int W_GATE_A  = 1;
    localparam int W_GATE_B  = 2;
    localparam int W_ALLOW_A = 3;
    localparam int W_ALLOW_B = 4;
    localparam int WIN_N     = 5;

    localparam logic [15:0] GATE_WIDTH_RESET = 16'd102;
    localparam logic [7:0]  DEAD_FRAMES_RESET = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TERM_MASKS    = 3'd0,
        REG_PRESCALE_VETO = 3'd1,
        REG_DEAD_FRAMES   = 3'd2,
        REG_GATE_A_WIDTH  = 3'd3,
        REG_GATE_B_WIDTH  = 3'd4,
        REG_ALLOW_A       = 3'd5,
        REG_ALLOW_B       = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [14:0] term_masks;
        logic [2:0]  prescale_veto;
        logic [7:0]  dead_frames;
        logic [15:0] gate_a_width;
        logic [15:0] gate_b_width;
        logic [31:0] allow_a;
        logic [31:0] allow_b;
    } cfg_t;

    typedef struct packed {
        logic [TICK_W-1:0] tick_time;
        logic              pmt_beam;
        logic              pmt_cosmic;
        logic              beam_a;
        logic              beam_b;
        logic              calib;
        logic              external;
        logic              pc_request;
    } cand_t;

    typedef struct packed {
        logic [TICK_W-1:0] dead_start;
        logic [END_W-1:0]  dead_end;
        logic [TICK_W-1:0] gate_a_start;
        logic [END_W-1:0]  gate_a_end;
        logic [TICK_W-1:0] gate_b_start;
        logic [END_W-1:0]  gate_b_end;
        logic [END_W-1:0]  allow_a_start;
        logic [END_W-1:0]  allow_a_end;
        logic [END_W-1:0]  allow_b_start;
        logic [END_W-1:0]  allow_b_end;
        logic [WIN_N-1:0]  window_valid;
        logic [TICK_W-1:0] trigger_count;
    } state_t;

    typedef struct packed {
        logic              accepted;
        logic [TICK_W-1:0] trigger_number;
        logic              in_dead_time;
        logic [2:0]        condition_bits;
    } result_t;

endpackage

/* hdl/mtdd_decide.sv */
module mtdd_decide #(
    parameter int FRAME_TICKS = 25600
) (
    input  mtdd_pkg::cfg_t    cfg,
    input  mtdd_pkg::state_t  st,
    input  mtdd_pkg::cand_t   cand,
    output mtdd_pkg::state_t  st_next,
    output mtdd_pkg::result_t res
);

    localparam int FT_W  = $clog2(FRAME_TICKS + 1);
    localparam int LEN_W = 8 + FT_W;

    logic [LEN_W-1:0]            dead_len;
    logic [mtdd_pkg::END_W-1:0]  t33;
    logic                        in_dead;
    logic                        act;
    logic                        ga;
    logic                        gb;
    logic [3:0]                  m0;
    logic [3:0]                  m1;
    logic [6:0]                  m8;
    logic                        v0;
    logic                        v1;
    logic                        v2;
    logic                        p0;
    logic                        p1;
    logic                        p8;
    logic [2:0]                  cond;

    assign dead_len = LEN_W'(cfg.dead_frames) * LEN_W'(FRAME_TICKS);
    assign t33      = {1'b0, cand.tick_time};

    assign in_dead = st.window_valid[mtdd_pkg::W_DEAD]
                     && cand.tick_time >= st.dead_start && t33 <= st.dead_end;

    assign act = (st.window_valid[mtdd_pkg::W_ALLOW_A]
                  && t33 >= st.allow_a_start && t33 <= st.allow_a_end)
              || (st.window_valid[mtdd_pkg::W_ALLOW_B]
                  && t33 >= st.allow_b_start && t33 <= st.allow_b_end);

    // a fresh beam flag opens a gate that starts at this tick
    assign ga = cand.beam_a || (st.window_valid[mtdd_pkg::W_GATE_A]
                && cand.tick_time >= st.gate_a_start && t33 <= st.gate_a_end);
    assign gb = cand.beam_b || (st.window_valid[mtdd_pkg::W_GATE_B]
                && cand.tick_time >= st.gate_b_start && t33 <= st.gate_b_end);

    assign m0 = cfg.term_masks[3:0];
    assign m1 = cfg.term_masks[7:4];
    assign m8 = cfg.term_masks[14:8];
    assign v0 = cfg.prescale_veto[0];
    assign v1 = cfg.prescale_veto[1];
    assign v2 = cfg.prescale_veto[2];

    assign p0 = cand.pmt_beam & ((gb & m0[0]) | (ga & m0[1])
                | (~v0 & ((act & m0[2]) | m0[3])));
    assign p1 = cand.pmt_cosmic & ((gb & m1[0]) | (ga & m1[1])
                | (~v1 & ((act & m1[2]) | m1[3])));
    assign p8 = (~v2 & cand.external & ((act & m8[0]) | m8[1]))
              | (cand.pc_request & ((act & m8[2]) | m8[3]))
              | (ga & m8[4]) | (gb & m8[5]) | (cand.calib & m8[6]);
    assign cond = {p8, p1, p0};

    always_comb
    begin
        st_next = st;
        res     = '0;
        if (in_dead)
        begin
            res.in_dead_time = 1'b1;
        end
        else
        begin
            res.condition_bits = cond;
            if (cand.beam_a)
            begin
                st_next.gate_a_start = cand.tick_time;
                st_next.gate_a_end   = t33 + mtdd_pkg::END_W'(cfg.gate_a_width);
                st_next.window_valid[mtdd_pkg::W_GATE_A] = 1'b1;
            end
            if (cand.beam_b)
            begin
                st_next.gate_b_start = cand.tick_time;
                st_next.gate_b_end   = t33 + mtdd_pkg::END_W'(cfg.gate_b_width);
                st_next.window_valid[mtdd_pkg::W_GATE_B] = 1'b1;
            end
            if (cond != 3'd0)
            begin
                if (dead_len != '0)
                begin
                    st_next.dead_start = cand.tick_time;
                    st_next.dead_end   = t33 + mtdd_pkg::END_W'(dead_len)
                                         - mtdd_pkg::END_W'(1);
                    st_next.window_valid[mtdd_pkg::W_DEAD] = 1'b1;
                end
                else
                begin
                    st_next.window_valid[mtdd_pkg::W_DEAD] = 1'b0;
                end
                if (cand.beam_a)
                begin
                    st_next.allow_a_start = t33 + mtdd_pkg::END_W'(cfg.allow_a[15:0]);
                    st_next.allow_a_end   = t33 + mtdd_pkg::END_W'(cfg.allow_a[31:16]);
                    st_next.window_valid[mtdd_pkg::W_ALLOW_A] = 1'b1;
                end
                if (cand.beam_b)
                begin
                    st_next.allow_b_start = t33 + mtdd_pkg::END_W'(cfg.allow_b[15:0]);
                    st_next.allow_b_end   = t33 + mtdd_pkg::END_W'(cfg.allow_b[31:16]);
                    st_next.window_valid[mtdd_pkg::W_ALLOW_B] = 1'b1;
                end
                res.accepted       = 1'b1;
                res.trigger_number = st.trigger_count;
                st_next.trigger_count = st.trigger_count + mtdd_pkg::TICK_W'(1);
            end
        end
    end

endmodule

/* hdl/masked_trigger_decision_with_deadtime_top.sv */
// Accepted candidates pass through the input register, then the result register, which drives m_tvalid.
// Throughput: one candidate per cycle while m_tready is high; the input register refills as results drain.
// The window and counter state updates in the same cycle that the result register loads.
// Reset: asynchronous, active low; all windows empty, trigger count zero, config registers at defaults.
// m_tready low holds the result register; the input register then holds one more candidate.
module masked_trigger_decision_with_deadtime_top #(
    parameter int FRAME_TICKS = 25600
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mtdd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtdd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tick_time[31:0], pmt_beam, pmt_cosmic, beam_a, beam_b, calib, external, pc_request, pad
    input  logic [mtdd_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // accepted, trigger_number[32:1], in_dead_time, condition_bits[36:34], pad
    output logic [mtdd_pkg::OUT_DATA_W-1:0]  m_tdata
);

    mtdd_pkg::cfg_t    cfg_reg;
    mtdd_pkg::cand_t   cand_reg;
    logic              in_valid_reg;
    mtdd_pkg::state_t  state_reg;
    mtdd_pkg::state_t  state_next;
    mtdd_pkg::result_t res_reg;
    mtdd_pkg::result_t res_next;
    logic              m_valid_reg;
    logic              load;
    logic              s_accept;

    assign load     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || load;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.term_masks    <= '0;
            cfg_reg.prescale_veto <= '0;
            cfg_reg.dead_frames   <= mtdd_pkg::DEAD_FRAMES_RESET;
            cfg_reg.gate_a_width  <= mtdd_pkg::GATE_WIDTH_RESET;
            cfg_reg.gate_b_width  <= mtdd_pkg::GATE_WIDTH_RESET;
            cfg_reg.allow_a       <= '0;
            cfg_reg.allow_b       <= '0;
        end
        else if (cfg_we)
        begin
            case (mtdd_pkg::reg_index_t'(cfg_index))
                mtdd_pkg::REG_TERM_MASKS:    cfg_reg.term_masks    <= cfg_data[14:0];
                mtdd_pkg::REG_PRESCALE_VETO: cfg_reg.prescale_veto <= cfg_data[2:0];
                mtdd_pkg::REG_DEAD_FRAMES:   cfg_reg.dead_frames   <= cfg_data[7:0];
                mtdd_pkg::REG_GATE_A_WIDTH:  cfg_reg.gate_a_width  <= cfg_data[15:0];
                mtdd_pkg::REG_GATE_B_WIDTH:  cfg_reg.gate_b_width  <= cfg_data[15:0];
                mtdd_pkg::REG_ALLOW_A:       cfg_reg.allow_a       <= cfg_data;
                mtdd_pkg::REG_ALLOW_B:       cfg_reg.allow_b       <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cand_reg.tick_time  <= s_tdata[31:0];
            cand_reg.pmt_beam   <= s_tdata[32];
            cand_reg.pmt_cosmic <= s_tdata[33];
            cand_reg.beam_a     <= s_tdata[34];
            cand_reg.beam_b     <= s_tdata[35];
            cand_reg.calib      <= s_tdata[36];
            cand_reg.external   <= s_tdata[37];
            cand_reg.pc_request <= s_tdata[38];
        end
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (load)
            begin
                m_valid_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    mtdd_decide #(
        .FRAME_TICKS (FRAME_TICKS)
    ) u_decide (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .cand    (cand_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, res_reg.condition_bits, res_reg.in_dead_time,
                       res_reg.trigger_number, res_reg.accepted};

    a_dead_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && res_reg.in_dead_time
        |-> !res_reg.accepted && res_reg.condition_bits == 3'd0)
        else $error("dead-time drop carries a decision");

    a_accept_cond: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> res_reg.accepted == (res_reg.condition_bits != 3'd0))
        else $error("accept flag disagrees with condition bits");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        load && res_next.accepted
        |=> state_reg.trigger_count == $past(state_reg.trigger_count) + 32'd1)
        else $error("trigger count did not advance on acceptance");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(state_reg))
        else $error("window state moved without a transaction");

    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_tready)
        else $error("input stalled while output register empty");

endmodule
